// ----- hdl/density_cluster_labeler_macros.svh -----
// Assertion macros used by the density cluster labeler checker.
// No dependencies; every use expands to one labeled concurrent assertion.
`ifndef DENSITY_CLUSTER_LABELER_MACROS_SVH
`define DENSITY_CLUSTER_LABELER_MACROS_SVH

// Assertion sampled on clk, held off while reset is asserted
`define DCL_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assertion sampled on clk, checked during reset as well
`define DCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/dcl_pkg.sv -----
// Shared constants and codes of the density cluster labeler.
// No dependencies.
package dcl_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int LBL_W      = 11;
	localparam int COORD_BITS = 24;
	localparam int EPS_W      = 23;
	localparam int MINP_W     = 11;
	localparam int DIMS_W     = 2;
	localparam int CIDX_W     = 2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_EPS     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MIN_PTS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_DIMS    = 2'd2;

	// request and result codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_READ    = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [DIMS_W-1:0] DIMS_3D = 2'd3;

	// label store entry: classified bit over the label
	typedef struct packed {
		logic             cls;
		logic [LBL_W-1:0] lbl;
	} lbl_entry_t;
endpackage

// ----- hdl/density_cluster_labeler.sv -----
// DBSCAN labeler over up to 1024 stored 2D or 3D points. Loads can follow back to
// back while no result word waits. A read answer is formed in S_RDW from the
// registered label memory read and blocks input until the answer word is taken.
// A load with last_point starts a run that holds stall high until the summary
// word is taken. Each neighbor search over the N loaded points runs a point
// memory read, difference, square and compare stage per point, plus setup and
// the core decision. A run makes one search for each unclassified point it
// visits and one for each seed it expands. It also makes a clearing pass over
// the label memory and runs the relabel steps.
// Depends on dcl_pkg, dcl_ram and dcl_dist.
module density_cluster_labeler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dcl_pkg::CIDX_W-1:0]            cfg_index,
	input  logic [dcl_pkg::EPS_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic signed [dcl_pkg::COORD_BITS-1:0] x_coord,
	input  logic signed [dcl_pkg::COORD_BITS-1:0] y_coord,
	input  logic signed [dcl_pkg::COORD_BITS-1:0] z_coord,
	input  logic                                  last_point,
	input  logic [dcl_pkg::IDX_W-1:0]             read_index,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  result_kind,
	output logic [dcl_pkg::LBL_W-1:0]             cluster_count,
	output logic [dcl_pkg::LBL_W-1:0]             label,
	output logic [1:0]                            status
);
	localparam int CW = dcl_pkg::CNT_W;
	localparam int IW = dcl_pkg::IDX_W;
	localparam int PW = 3 * dcl_pkg::COORD_BITS;
	localparam int EW = dcl_pkg::LBL_W + 1;
	localparam logic [CW-1:0] MAXP = CW'(dcl_pkg::MAX_POINTS);

	localparam logic [4:0] S_IDLE = 5'd0,  S_RDW  = 5'd1,  S_CLR  = 5'd2,
		S_OI   = 5'd3,  S_OICK = 5'd4,  S_GC   = 5'd5,  S_GCL  = 5'd6,
		S_GRD  = 5'd7,  S_GDIF = 5'd8,  S_GSQ  = 5'd9,  S_GCMP = 5'd10,
		S_PDEC = 5'd11, S_KRD  = 5'd12, S_KWR  = 5'd13, S_HCHK = 5'd14,
		S_HLAT = 5'd15, S_NDEC = 5'd16, S_NRD  = 5'd17, S_NLBL = 5'd18,
		S_NUPD = 5'd19;

	logic [4:0] st_q;
	logic [dcl_pkg::EPS_W-1:0]  eps_q;
	logic [dcl_pkg::MINP_W-1:0] min_pts_q;
	logic [dcl_pkg::DIMS_W-1:0] dims_q;
	logic [CW-1:0] pc_q, i_q, j_q, n_q, cnt_q, head_q, k_q, ctr_q;
	logic [dcl_pkg::LBL_W-1:0] cid_q, clusters_q;
	logic overflow_q, set_done_q, gmode_q, rd_ok_q;
	logic out_valid_q, kind_q;
	logic [dcl_pkg::LBL_W-1:0] label_q;
	logic [1:0] status_q;

	logic acc, acc_load, acc_read;
	logic [CW-1:0] eff_pc;
	logic near;

	logic xyz_we;
	logic [IW-1:0] xyz_waddr, xyz_raddr;
	logic [PW-1:0] xyz_wdata, xyz_rdata;
	logic lbl_we;
	logic [IW-1:0] lbl_waddr, lbl_raddr;
	dcl_pkg::lbl_entry_t lbl_wdata, lbl_rdata;
	logic seed_we, nbr_we;
	logic [IW-1:0] seed_waddr, seed_wdata, seed_raddr, seed_rdata;
	logic [IW-1:0] nbr_waddr, nbr_raddr, nbr_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != S_IDLE) || out_valid_q;
	assign acc       = in_valid && !in_stall;
	assign acc_load  = acc && (req_type == dcl_pkg::REQ_LOAD);
	assign acc_read  = acc && (req_type == dcl_pkg::REQ_READ);
	assign eff_pc    = set_done_q ? '0 : pc_q;

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign cluster_count = clusters_q;
	assign label         = label_q;
	assign status        = status_q;

	// memory port steering
	always_comb begin
		xyz_we    = acc_load && (eff_pc < MAXP);
		xyz_waddr = eff_pc[IW-1:0];
		xyz_wdata = {z_coord, y_coord, x_coord};
		xyz_raddr = (st_q == S_GC) ? ctr_q[IW-1:0] : j_q[IW-1:0];

		case (st_q)
			S_IDLE:  lbl_raddr = read_index;
			S_OI:    lbl_raddr = i_q[IW-1:0];
			default: lbl_raddr = nbr_rdata;
		endcase

		lbl_we    = 1'b0;
		lbl_waddr = ctr_q[IW-1:0];
		lbl_wdata = '{cls: 1'b1, lbl: cid_q};
		seed_we    = 1'b0;
		seed_waddr = n_q[IW-1:0];
		seed_wdata = j_q[IW-1:0];
		nbr_we     = st_q == S_GCMP && near && gmode_q;
		nbr_waddr  = n_q[IW-1:0];
		case (st_q)
			S_CLR: begin
				lbl_we    = j_q != pc_q;
				lbl_waddr = j_q[IW-1:0];
				lbl_wdata = '{cls: 1'b0, lbl: '0};
			end
			S_GCMP: seed_we = near && !gmode_q;
			S_PDEC: begin
				lbl_we    = n_q < CW'(min_pts_q);
				lbl_wdata = '{cls: 1'b1, lbl: '0};
			end
			S_KWR: begin
				lbl_we    = 1'b1;
				lbl_waddr = seed_rdata;
			end
			S_NUPD: begin
				lbl_waddr  = ctr_q[IW-1:0];
				lbl_we     = !lbl_rdata.cls || (lbl_rdata.lbl == '0);
				seed_we    = !lbl_rdata.cls && (cnt_q < MAXP);
				seed_waddr = cnt_q[IW-1:0];
				seed_wdata = ctr_q[IW-1:0];
			end
			default: ;
		endcase
		seed_raddr = (st_q == S_KRD) ? k_q[IW-1:0] : head_q[IW-1:0];
		nbr_raddr  = k_q[IW-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q     <= dcl_pkg::EPS_W'(256);
			min_pts_q <= dcl_pkg::MINP_W'(4);
			dims_q    <= dcl_pkg::DIMS_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dcl_pkg::REG_EPS:     eps_q     <= cfg_data;
				dcl_pkg::REG_MIN_PTS: min_pts_q <= cfg_data[dcl_pkg::MINP_W-1:0];
				dcl_pkg::REG_DIMS:    dims_q    <= cfg_data[dcl_pkg::DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			pc_q        <= '0;
			clusters_q  <= '0;
			overflow_q  <= 1'b0;
			set_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
			i_q <= '0; j_q <= '0; n_q <= '0; cnt_q <= '0; head_q <= '0;
			k_q <= '0; ctr_q <= '0; cid_q <= '0; gmode_q <= 1'b0; rd_ok_q <= 1'b0;
			kind_q <= 1'b0; label_q <= '0; status_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc_load) begin
						set_done_q <= 1'b0;
						if (eff_pc < MAXP) begin
							pc_q       <= eff_pc + 1'b1;
							overflow_q <= set_done_q ? 1'b0 : overflow_q;
						end else begin
							pc_q       <= eff_pc;
							overflow_q <= 1'b1;
						end
						if (last_point) begin
							j_q  <= '0;
							st_q <= S_CLR;
						end
					end else if (acc_read) begin
						rd_ok_q <= set_done_q && (CW'(read_index) < pc_q);
						st_q    <= S_RDW;
					end
				end
				S_RDW: begin
					out_valid_q <= 1'b1;
					kind_q      <= dcl_pkg::KIND_READ;
					label_q     <= rd_ok_q ? lbl_rdata.lbl : '0;
					status_q    <= rd_ok_q ? dcl_pkg::ST_OK : dcl_pkg::ST_RANGE;
					st_q        <= S_IDLE;
				end
				// clear classified bits of the loaded points
				S_CLR: begin
					if (j_q == pc_q) begin
						i_q   <= '0;
						cid_q <= '0;
						st_q  <= S_OI;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_OI: begin
					if (i_q == pc_q) begin
						clusters_q  <= cid_q;
						set_done_q  <= 1'b1;
						out_valid_q <= 1'b1;
						kind_q      <= dcl_pkg::KIND_SUMMARY;
						label_q     <= '0;
						status_q    <= overflow_q ? dcl_pkg::ST_OVERFLOW : dcl_pkg::ST_OK;
						st_q        <= S_IDLE;
					end else begin
						st_q <= S_OICK;
					end
				end
				S_OICK: begin
					if (lbl_rdata.cls) begin
						i_q  <= i_q + 1'b1;
						st_q <= S_OI;
					end else begin
						ctr_q   <= i_q;
						gmode_q <= 1'b0;
						st_q    <= S_GC;
					end
				end
				// neighbor search around ctr_q
				S_GC:  st_q <= S_GCL;
				S_GCL: begin
					j_q  <= '0;
					n_q  <= '0;
					st_q <= S_GRD;
				end
				S_GRD:  st_q <= S_GDIF;
				S_GDIF: st_q <= S_GSQ;
				S_GSQ:  st_q <= S_GCMP;
				S_GCMP: begin
					if (near) begin
						n_q <= n_q + 1'b1;
					end
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == pc_q) begin
						st_q <= gmode_q ? S_NDEC : S_PDEC;
					end else begin
						st_q <= S_GRD;
					end
				end
				S_PDEC: begin
					if (n_q < CW'(min_pts_q)) begin
						i_q  <= i_q + 1'b1;
						st_q <= S_OI;
					end else begin
						cid_q  <= cid_q + 1'b1;
						cnt_q  <= n_q;
						k_q    <= '0;
						head_q <= '0;
						st_q   <= S_KRD;
					end
				end
				// relabel the initial seeds
				S_KRD: st_q <= S_KWR;
				S_KWR: begin
					k_q  <= k_q + 1'b1;
					st_q <= (k_q + 1'b1 == cnt_q) ? S_HCHK : S_KRD;
				end
				// breadth-first expansion
				S_HCHK: begin
					if (head_q == cnt_q) begin
						i_q  <= i_q + 1'b1;
						st_q <= S_OI;
					end else begin
						head_q <= head_q + 1'b1;
						st_q   <= S_HLAT;
					end
				end
				S_HLAT: begin
					ctr_q   <= CW'(seed_rdata);
					gmode_q <= 1'b1;
					st_q    <= S_GC;
				end
				S_NDEC: begin
					k_q  <= '0;
					st_q <= (n_q < CW'(min_pts_q)) ? S_HCHK : S_NRD;
				end
				S_NRD:  st_q <= S_NLBL;
				S_NLBL: begin
					ctr_q <= CW'(nbr_rdata);
					st_q  <= S_NUPD;
				end
				S_NUPD: begin
					if (!lbl_rdata.cls && (cnt_q < MAXP)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					k_q  <= k_q + 1'b1;
					st_q <= (k_q + 1'b1 == n_q) ? S_HCHK : S_NRD;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	dcl_ram #(.WIDTH(PW), .DEPTH(dcl_pkg::MAX_POINTS)) u_xyz (
		.clk(clk), .we(xyz_we), .waddr(xyz_waddr), .wdata(xyz_wdata),
		.raddr(xyz_raddr), .rdata(xyz_rdata)
	);

	dcl_ram #(.WIDTH(EW), .DEPTH(dcl_pkg::MAX_POINTS)) u_lbl (
		.clk(clk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
		.raddr(lbl_raddr), .rdata(lbl_rdata)
	);

	dcl_ram #(.WIDTH(IW), .DEPTH(dcl_pkg::MAX_POINTS)) u_seed (
		.clk(clk), .we(seed_we), .waddr(seed_waddr), .wdata(seed_wdata),
		.raddr(seed_raddr), .rdata(seed_rdata)
	);

	dcl_ram #(.WIDTH(IW), .DEPTH(dcl_pkg::MAX_POINTS)) u_nbr (
		.clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(j_q[IW-1:0]),
		.raddr(nbr_raddr), .rdata(nbr_rdata)
	);

	dcl_dist u_dist (
		.clk(clk),
		.ld_ctr(st_q == S_GCL),
		.x_rd(xyz_rdata[dcl_pkg::COORD_BITS-1:0]),
		.y_rd(xyz_rdata[2*dcl_pkg::COORD_BITS-1:dcl_pkg::COORD_BITS]),
		.z_rd(xyz_rdata[PW-1:2*dcl_pkg::COORD_BITS]),
		.eps(eps_q),
		.dims(dims_q),
		.near(near)
	);
endmodule

// ----- hdl/dcl_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/dcl_dist.sv -----
// Neighborhood test pipeline: differences, squares, then radius compare.
// Depends on dcl_pkg. Free running; the data passes the absolute difference and square registers before near.
module dcl_dist (
	input  logic                                   clk,
	input  logic                                   ld_ctr,
	input  logic signed [dcl_pkg::COORD_BITS-1:0]  x_rd,
	input  logic signed [dcl_pkg::COORD_BITS-1:0]  y_rd,
	input  logic signed [dcl_pkg::COORD_BITS-1:0]  z_rd,
	input  logic [dcl_pkg::EPS_W-1:0]              eps,
	input  logic [dcl_pkg::DIMS_W-1:0]             dims,
	output logic                                   near
);
	localparam int DW = dcl_pkg::COORD_BITS + 1;
	localparam int SW = 2 * DW;

	logic signed [dcl_pkg::COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic signed [DW-1:0] ddx, ddy, ddz;
	logic [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [SW-1:0] sx_s2, sy_s2, sz_s2;
	logic          far_s2;
	logic [2*dcl_pkg::EPS_W-1:0] eps_sq_q;
	logic [SW+1:0] sum;

	// hold the center point and register eps squared
	always_ff @(posedge clk) begin
		if (ld_ctr) begin
			cx_q <= x_rd;
			cy_q <= y_rd;
			cz_q <= z_rd;
		end
		eps_sq_q <= eps * eps;
	end

	always_comb begin
		ddx = DW'(x_rd) - DW'(cx_q);
		ddy = DW'(y_rd) - DW'(cy_q);
		ddz = DW'(z_rd) - DW'(cz_q);
	end

	// absolute differences, then squares and the per-axis radius check
	always_ff @(posedge clk) begin
		dx_s1 <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
		dy_s1 <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
		dz_s1 <= (dims == dcl_pkg::DIMS_3D) ? (ddz[DW-1] ? DW'(-ddz) : DW'(ddz)) : '0;
		sx_s2 <= dx_s1 * dx_s1;
		sy_s2 <= dy_s1 * dy_s1;
		sz_s2 <= dz_s1 * dz_s1;
		far_s2 <= (dx_s1 > DW'(eps)) || (dy_s1 > DW'(eps)) || (dz_s1 > DW'(eps));
	end

	assign sum  = (SW+2)'(sx_s2) + (SW+2)'(sy_s2) + (SW+2)'(sz_s2);
	assign near = !far_s2 && (sum <= (SW+2)'(eps_sq_q));
endmodule

// ----- hdl/dcl_checker.sv -----
// Port-level checker for the density cluster labeler, bound to the top level.
// Depends on dcl_pkg and density_cluster_labeler_macros.svh.
`include "density_cluster_labeler_macros.svh"

module dcl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          result_kind,
	input logic [dcl_pkg::LBL_W-1:0]     label,
	input logic [1:0]                    status
);
	// hold a stalled result word
	`DCL_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(label) && $stable(status), "stalled result changed")
	// summary words never carry a label or a range error
	`DCL_ASSERT_RST(a_sum_shape, out_valid && result_kind == dcl_pkg::KIND_SUMMARY |-> label == '0 && status != dcl_pkg::ST_RANGE, "bad summary word")
	// read answers never report overflow, range errors give label zero
	`DCL_ASSERT_RST(a_read_shape, out_valid && result_kind == dcl_pkg::KIND_READ |-> status != dcl_pkg::ST_OVERFLOW && (status == dcl_pkg::ST_OK || label == '0), "bad read answer")
	// drop no input while a result waits
	`DCL_ASSERT(a_in_block, out_valid && arst_n |-> in_stall, "input taken while result pending")
endmodule

bind density_cluster_labeler dcl_checker u_dcl_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
	.label(label), .status(status)
);
